### hdl/lom_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the limit order matcher.
// Used by the slot cell and the top level.
package lom_pkg;

   localparam int REQ_W    = 2;
   localparam int PRICE_W  = 20;
   localparam int QTY_W    = 24;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 3;
   localparam int TRADE_W  = ID_W + PRICE_W + QTY_W;

   localparam logic [REQ_W-1:0] REQ_NEW    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
   localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

   localparam logic SIDE_BUY    = 1'b0;
   localparam logic KIND_LIMIT  = 1'b0;

   localparam logic [STATUS_W-1:0] ST_DONE        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RESTED      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CANCELLED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CANCEL_FAIL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MOD_KEPT    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_MOD_REQUEUE = 3'd6;
   localparam logic [STATUS_W-1:0] ST_MOD_REJECT  = 3'd7;

   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_FILL    = 3'd1;
   localparam logic [2:0] CMD_CLEAR   = 3'd2;
   localparam logic [2:0] CMD_REST    = 3'd3;
   localparam logic [2:0] CMD_SETQ    = 3'd4;
   localparam logic [2:0] CMD_REQUEUE = 3'd5;

   // Update broadcast to every cell; only the addressed cell acts on it.
   typedef struct packed {
      logic [2:0]         op;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [ID_W-1:0]    id;
      logic [ID_W-1:0]    stamp;
   } cmd_type;

   // Search results handed from cell to cell.
   typedef struct packed {
      logic               best_found;
      logic [PRICE_W-1:0] best_price;
      logic [ID_W-1:0]    best_age;
      logic [QTY_W-1:0]   best_qty;
      logic [ID_W-1:0]    best_id;
      logic               id_found;
      logic [PRICE_W-1:0] id_price;
      logic [QTY_W-1:0]   id_qty;
      logic               free_found;
   } cand_type;

endpackage

### hdl/lom_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lom_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lom_cell.sv
`timescale 1ns / 1ps
// One slot of the order store plus its stage of the search chain.
// Depends on lom_pkg.
module lom_cell #(
   parameter int POOL_ENTRIES = 64,
   parameter int CELL_INDEX   = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lom_pkg::cmd_type                cmd,
   input  logic [$clog2(POOL_ENTRIES)-1:0] cmd_idx,
   input  logic                            opp_side,
   input  logic [lom_pkg::ID_W-1:0]        target_id,
   input  logic [lom_pkg::ID_W-1:0]        next_stamp,
   input  lom_pkg::cand_type               cand_in,
   input  logic [$clog2(POOL_ENTRIES)-1:0] best_idx_in,
   input  logic [$clog2(POOL_ENTRIES)-1:0] id_idx_in,
   input  logic [$clog2(POOL_ENTRIES)-1:0] free_idx_in,
   output lom_pkg::cand_type               cand_out,
   output logic [$clog2(POOL_ENTRIES)-1:0] best_idx_out,
   output logic [$clog2(POOL_ENTRIES)-1:0] id_idx_out,
   output logic [$clog2(POOL_ENTRIES)-1:0] free_idx_out
);
   import lom_pkg::*;

   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic               used_ff;
   logic               side_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic [ID_W-1:0]    id_ff;
   logic [ID_W-1:0]    stamp_ff;

   cand_type           cand_in_w;
   cand_type           cand_ff;
   logic [IDX_W-1:0]   best_idx_in_w, best_idx_ff;
   logic [IDX_W-1:0]   id_idx_in_w, id_idx_ff;
   logic [IDX_W-1:0]   free_idx_in_w, free_idx_ff;
   logic [ID_W-1:0]    age;
   logic               better_price;
   logic               take_best;
   logic               hit;

   // Lower cells hold lower slot numbers, so a tie keeps the earlier candidate.
   always_comb begin
      age = next_stamp - stamp_ff;
      if (opp_side) begin
         better_price = price_ff < cand_in.best_price;
      end else begin
         better_price = price_ff > cand_in.best_price;
      end
      take_best = used_ff && (side_ff == opp_side) &&
                  (!cand_in.best_found || better_price ||
                   (price_ff == cand_in.best_price && age > cand_in.best_age));
      cand_in_w     = cand_in;
      best_idx_in_w = best_idx_in;
      id_idx_in_w   = id_idx_in;
      free_idx_in_w = free_idx_in;
      if (take_best) begin
         cand_in_w.best_found = 1'b1;
         cand_in_w.best_price = price_ff;
         cand_in_w.best_age   = age;
         cand_in_w.best_qty   = qty_ff;
         cand_in_w.best_id    = id_ff;
         best_idx_in_w        = MY_IDX;
      end
      if (!cand_in.id_found && used_ff && id_ff == target_id) begin
         cand_in_w.id_found = 1'b1;
         cand_in_w.id_price = price_ff;
         cand_in_w.id_qty   = qty_ff;
         id_idx_in_w        = MY_IDX;
      end
      if (!cand_in.free_found && !used_ff) begin
         cand_in_w.free_found = 1'b1;
         free_idx_in_w        = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in_w;
      best_idx_ff <= best_idx_in_w;
      id_idx_ff   <= id_idx_in_w;
      free_idx_ff <= free_idx_in_w;
   end

   assign hit = (cmd_idx == MY_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (hit) begin
         case (cmd.op)
            CMD_FILL: begin
               if (qty_ff == cmd.qty) begin
                  used_ff <= 1'b0;
               end
            end
            CMD_CLEAR: used_ff <= 1'b0;
            CMD_REST:  used_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         case (cmd.op)
            CMD_FILL: qty_ff <= qty_ff - cmd.qty;
            CMD_REST: begin
               side_ff  <= cmd.side;
               price_ff <= cmd.price;
               qty_ff   <= cmd.qty;
               id_ff    <= cmd.id;
               stamp_ff <= cmd.stamp;
            end
            CMD_SETQ: qty_ff <= cmd.qty;
            CMD_REQUEUE: begin
               price_ff <= cmd.price;
               qty_ff   <= cmd.qty;
               stamp_ff <= cmd.stamp;
            end
            default: ;
         endcase
      end
   end

   assign cand_out     = cand_ff;
   assign best_idx_out = best_idx_ff;
   assign id_idx_out   = id_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

### hdl/limit_order_matcher.sv
`timescale 1ns / 1ps
// Limit order matcher: a chain of slot cells, a trade buffer and the sequencer.
// Depends on lom_pkg, lom_cell and lom_ram.
//
// Usage. One request item enters on the req_ channel (new order, cancel or
// modify). The block answers with one or more items on the rsp_ channel: one
// item per trade of a new order, or a single item without a trade. Every item
// of a request carries the same own_id and final status; rsp_last marks the
// final one. Both channels are valid/ready; req_ready is high only while the
// block is between requests.
// The store is a row of POOL_ENTRIES cells. The search for the best opposite
// order, the order with a given id and the lowest free slot travels along the
// row one cell per cycle. A new order runs one search per trade, plus one
// more unless its last trade used it up; a cancel or modify runs one search;
// a zero quantity order or an unknown request runs none. Trades are written
// to a buffer RAM and handed out afterwards, one item per pass through the
// read and output states.
// Reset empties the store and clears the id and stamp counters; no clearing
// pass is needed. A result item waits in the output register while the
// receiver stalls; the block may already accept the next request then.
module limit_order_matcher #(
   parameter int POOL_ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lom_pkg::REQ_W-1:0]    req_type,
   input  logic                         req_side,
   input  logic                         req_order_kind,
   input  logic [lom_pkg::PRICE_W-1:0]  req_price,
   input  logic [lom_pkg::QTY_W-1:0]    req_quantity,
   input  logic [lom_pkg::ID_W-1:0]     req_target_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_has_trade,
   output logic [lom_pkg::ID_W-1:0]     rsp_buyer_id,
   output logic [lom_pkg::ID_W-1:0]     rsp_seller_id,
   output logic [lom_pkg::PRICE_W-1:0]  rsp_trade_price,
   output logic [lom_pkg::QTY_W-1:0]    rsp_trade_quantity,
   output logic [lom_pkg::ID_W-1:0]     rsp_own_id,
   output logic [lom_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_last
);
   import lom_pkg::*;

   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_RD     = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [REQ_W-1:0]    type_ff, type_in;
   logic                side_ff, side_in;
   logic                kind_ff, kind_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic [QTY_W-1:0]    qrem_ff, qrem_in;
   logic [ID_W-1:0]     tid_ff, tid_in;
   logic [ID_W-1:0]     own_ff, own_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    ntr_ff, ntr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [ID_W-1:0]     next_id_ff, next_id_in;
   logic [ID_W-1:0]     next_stamp_ff, next_stamp_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_has_trade_ff, rsp_has_trade_in;
   logic [ID_W-1:0]     rsp_buyer_ff, rsp_buyer_in;
   logic [ID_W-1:0]     rsp_seller_ff, rsp_seller_in;
   logic [PRICE_W-1:0]  rsp_price_ff, rsp_price_in;
   logic [QTY_W-1:0]    rsp_qty_ff, rsp_qty_in;
   logic [ID_W-1:0]     rsp_own_ff, rsp_own_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   cmd_type             cmd;
   logic [IDX_W-1:0]    cmd_idx;

   cand_type            cand_chain [POOL_ENTRIES];
   logic [IDX_W-1:0]    best_chain [POOL_ENTRIES];
   logic [IDX_W-1:0]    id_chain   [POOL_ENTRIES];
   logic [IDX_W-1:0]    free_chain [POOL_ENTRIES];
   cand_type            cand_end;

   logic                ram_wr_en;
   logic [TRADE_W-1:0]  ram_wr_data;
   logic [TRADE_W-1:0]  ram_rd_data;
   logic [ID_W-1:0]     rd_id;
   logic [PRICE_W-1:0]  rd_price;
   logic [QTY_W-1:0]    rd_qty;

   logic [QTY_W-1:0]    fill;
   logic                crosses;
   logic                mod_ok;
   logic                item_last;
   logic                out_free;

   // ---------------------------------------------------------------
   // Cell row. The first cell always sees an empty candidate, so the
   // row output settles once the last update has passed every cell.
   // ---------------------------------------------------------------
   for (genvar g = 0; g < POOL_ENTRIES; g++) begin : g_cell
      cand_type         c_in;
      logic [IDX_W-1:0] b_in, i_in, f_in;
      if (g == 0) begin : g_head
         assign c_in = '0;
         assign b_in = '0;
         assign i_in = '0;
         assign f_in = '0;
      end else begin : g_link
         assign c_in = cand_chain[g-1];
         assign b_in = best_chain[g-1];
         assign i_in = id_chain[g-1];
         assign f_in = free_chain[g-1];
      end
      lom_cell #(
         .POOL_ENTRIES (POOL_ENTRIES),
         .CELL_INDEX   (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .cmd_idx      (cmd_idx),
         .opp_side     (~side_ff),
         .target_id    (tid_ff),
         .next_stamp   (next_stamp_ff),
         .cand_in      (c_in),
         .best_idx_in  (b_in),
         .id_idx_in    (i_in),
         .free_idx_in  (f_in),
         .cand_out     (cand_chain[g]),
         .best_idx_out (best_chain[g]),
         .id_idx_out   (id_chain[g]),
         .free_idx_out (free_chain[g])
      );
   end

   assign cand_end = cand_chain[POOL_ENTRIES-1];

   // Trade buffer: resting order id, resting price and fill per trade.
   lom_ram #(
      .WIDTH (TRADE_W),
      .DEPTH (POOL_ENTRIES)
   ) u_trades (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ntr_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_id    = ram_rd_data[TRADE_W-1 -: ID_W];
   assign rd_price = ram_rd_data[QTY_W +: PRICE_W];
   assign rd_qty   = ram_rd_data[QTY_W-1:0];

   always_comb begin
      fill = (qrem_ff < cand_end.best_qty) ? qrem_ff : cand_end.best_qty;
      // A market order crosses any resting opposite order; a limit order crosses at or through
      // the resting price. No trade once the item budget is used up.
      crosses = cand_end.best_found && (ntr_ff < CNT_W'(POOL_ENTRIES)) &&
                ((kind_ff != KIND_LIMIT) ||
                 ((side_ff == SIDE_BUY) ? (price_ff >= cand_end.best_price)
                                        : (price_ff <= cand_end.best_price)));
      mod_ok = cand_end.id_found && (price_ff != '0) && (qrem_ff != '0) &&
               !(price_ff == cand_end.id_price && qrem_ff == cand_end.id_qty);
      item_last = (ntr_ff == '0) || ((CNT_W'(ptr_ff) + CNT_W'(1)) == ntr_ff);
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // ---------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      side_in       = side_ff;
      kind_in       = kind_ff;
      price_in      = price_ff;
      qrem_in       = qrem_ff;
      tid_in        = tid_ff;
      own_in        = own_ff;
      status_in     = status_ff;
      ntr_in        = ntr_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      next_id_in    = next_id_ff;
      next_stamp_in = next_stamp_ff;

      cmd           = '0;
      cmd.op        = CMD_NONE;
      cmd_idx       = '0;
      ram_wr_en     = 1'b0;
      ram_wr_data   = {cand_end.best_id, cand_end.best_price, fill};

      rsp_has_trade_in = rsp_has_trade_ff;
      rsp_buyer_in     = rsp_buyer_ff;
      rsp_seller_in    = rsp_seller_ff;
      rsp_price_in     = rsp_price_ff;
      rsp_qty_in       = rsp_qty_ff;
      rsp_own_in       = rsp_own_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in   = req_type;
               side_in   = req_side;
               kind_in   = req_order_kind;
               price_in  = req_price;
               qrem_in   = req_quantity;
               tid_in    = req_target_id;
               own_in    = req_target_id;
               status_in = ST_DONE;
               ntr_in    = '0;
               cnt_in    = '0;
               ptr_in    = '0;
               state_in  = S_SEARCH;
               if (req_type == REQ_NEW) begin
                  own_in     = next_id_ff;
                  next_id_in = next_id_ff + ID_W'(1);
                  if (req_quantity == '0) begin
                     state_in = S_RD;
                  end
               end else if (req_type != REQ_CANCEL && req_type != REQ_MODIFY) begin
                  // Unknown request code: one empty item, nothing changes.
                  state_in = S_RD;
               end
            end
         end
         S_SEARCH: begin
            if (cnt_ff != CNT_W'(POOL_ENTRIES)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               cnt_in   = '0;
               state_in = S_RD;
               case (type_ff)
                  REQ_NEW: begin
                     if (crosses) begin
                        cmd.op    = CMD_FILL;
                        cmd.qty   = fill;
                        cmd_idx   = best_chain[POOL_ENTRIES-1];
                        ram_wr_en = 1'b1;
                        ntr_in    = ntr_ff + CNT_W'(1);
                        qrem_in   = qrem_ff - fill;
                        // Search again unless the order is used up; the
                        // next pass also finds a free slot for a remainder.
                        if (qrem_ff != fill) begin
                           state_in = S_SEARCH;
                        end
                     end else if (kind_ff == KIND_LIMIT) begin
                        if (cand_end.free_found) begin
                           cmd.op        = CMD_REST;
                           cmd.side      = side_ff;
                           cmd.price     = price_ff;
                           cmd.qty       = qrem_ff;
                           cmd.id        = own_ff;
                           cmd.stamp     = next_stamp_ff;
                           cmd_idx       = free_chain[POOL_ENTRIES-1];
                           next_stamp_in = next_stamp_ff + ID_W'(1);
                           status_in     = ST_RESTED;
                        end else begin
                           status_in = ST_FULL;
                        end
                     end
                  end
                  REQ_CANCEL: begin
                     if (cand_end.id_found) begin
                        cmd.op    = CMD_CLEAR;
                        cmd_idx   = id_chain[POOL_ENTRIES-1];
                        status_in = ST_CANCELLED;
                     end else begin
                        status_in = ST_CANCEL_FAIL;
                     end
                  end
                  default: begin
                     cmd_idx   = id_chain[POOL_ENTRIES-1];
                     cmd.price = price_ff;
                     cmd.qty   = qrem_ff;
                     cmd.stamp = next_stamp_ff;
                     if (!mod_ok) begin
                        status_in = ST_MOD_REJECT;
                     end else if (price_ff == cand_end.id_price &&
                                  qrem_ff < cand_end.id_qty) begin
                        cmd.op    = CMD_SETQ;
                        status_in = ST_MOD_KEPT;
                     end else begin
                        cmd.op        = CMD_REQUEUE;
                        next_stamp_in = next_stamp_ff + ID_W'(1);
                        status_in     = ST_MOD_REQUEUE;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            // The trade buffer read of this item completes in this cycle.
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_has_trade_in = (ntr_ff != '0);
               rsp_own_in       = own_ff;
               rsp_status_in    = status_ff;
               rsp_last_in      = item_last;
               if (ntr_ff != '0) begin
                  rsp_buyer_in  = (side_ff == SIDE_BUY) ? own_ff : rd_id;
                  rsp_seller_in = (side_ff == SIDE_BUY) ? rd_id : own_ff;
                  rsp_price_in  = rd_price;
                  rsp_qty_in    = rd_qty;
               end else begin
                  rsp_buyer_in  = '0;
                  rsp_seller_in = '0;
                  rsp_price_in  = '0;
                  rsp_qty_in    = '0;
               end
               if (item_last) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + IDX_W'(1);
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ntr_ff        <= '0;
         cnt_ff        <= '0;
         ptr_ff        <= '0;
         next_id_ff    <= '0;
         next_stamp_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ntr_ff        <= ntr_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
         next_id_ff    <= next_id_in;
         next_stamp_ff <= next_stamp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff          <= type_in;
      side_ff          <= side_in;
      kind_ff          <= kind_in;
      price_ff         <= price_in;
      qrem_ff          <= qrem_in;
      tid_ff           <= tid_in;
      own_ff           <= own_in;
      status_ff        <= status_in;
      rsp_has_trade_ff <= rsp_has_trade_in;
      rsp_buyer_ff     <= rsp_buyer_in;
      rsp_seller_ff    <= rsp_seller_in;
      rsp_price_ff     <= rsp_price_in;
      rsp_qty_ff       <= rsp_qty_in;
      rsp_own_ff       <= rsp_own_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_has_trade      = rsp_has_trade_ff;
   assign rsp_buyer_id       = rsp_buyer_ff;
   assign rsp_seller_id      = rsp_seller_ff;
   assign rsp_trade_price    = rsp_price_ff;
   assign rsp_trade_quantity = rsp_qty_ff;
   assign rsp_own_id         = rsp_own_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTHESIS
   a_ntr_bound : assert property (@(posedge clock) disable iff (reset)
      ntr_ff <= CNT_W'(POOL_ENTRIES))
      else $error("trade count beyond store size");

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(POOL_ENTRIES))
      else $error("search counter beyond chain length");

   a_search_type : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |->
         (type_ff == REQ_NEW || type_ff == REQ_CANCEL || type_ff == REQ_MODIFY))
      else $error("search started for an unknown request");

   a_trade_item : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free && ntr_ff != '0) |=>
         (rsp_valid_ff && rsp_has_trade_ff))
      else $error("trade item not presented");
`endif

endmodule
